/* rtl/core/mbk_pkg.sv */
// Package for the Morse beacon keyer: operation codes, timing constants and the
// fixed pattern ROM with its lookup function.
// No dependencies; used by morse_beacon_keyer_unit.
`default_nettype none

package mbk_pkg;

    // Kind of input transaction (travels on tuser)
    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_WRITE = 1'b1
    } t_op;

    localparam int unsigned DATA_W = 16;   // both stream tdata buses

    // Pattern coding: 2 bits per element from the top, 01 dit, 11 dah, 00 end
    localparam logic [15:0] PAT_TOP = 16'hC000;
    localparam logic [1:0]  SIG_END = 2'b00;
    localparam logic [1:0]  SIG_DAH = 2'b11;

    // Timing in units
    localparam logic [7:0] DAH_UNITS  = 8'd3;
    localparam logic [7:0] DIT_UNITS  = 8'd1;
    localparam logic [2:0] GAP_ELEM   = 3'd1;
    localparam logic [2:0] GAP_LETTER = 3'd2;
    localparam logic [2:0] GAP_WORD   = 3'd6;

    // Character codes
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] LOWER_A    = 8'd97;
    localparam logic [7:0] LOWER_Z    = 8'd122;
    localparam logic [7:0] CASE_DIFF  = 8'd32;
    localparam logic [7:0] ROM_FIRST  = 8'd33;
    localparam logic [7:0] ROM_LAST   = 8'd95;
    localparam int unsigned ROM_DEPTH = 63;

    // Patterns for ASCII '!' through '_'; holes hold zero
    localparam logic [15:0] MORSE_ROM [ROM_DEPTH] = '{
        16'hDDF0, 16'h75D0, 16'h0000, 16'h575C, 16'h0000, 16'h7540, 16'h7FD0, 16'hDF40,
        16'hDF70, 16'h0000, 16'h7740, 16'hF5F0, 16'hD570, 16'h7770, 16'hD740,
        16'hFFC0, 16'h7FC0, 16'h5FC0, 16'h57C0, 16'h55C0, 16'h5540, 16'hD540, 16'hF540,
        16'hFD40, 16'hFF40, 16'hFD50, 16'hDDD0, 16'h0000, 16'hD5C0, 16'h0000, 16'h5F50,
        16'h7DD0,
        16'h7000, 16'hD500, 16'hDD00, 16'hD400, 16'h4000, 16'h5D00, 16'hF400, 16'h5500,
        16'h5000, 16'h7F00, 16'hDC00, 16'h7500, 16'hF000, 16'hD000, 16'hFC00, 16'h7D00,
        16'hF700, 16'h7400, 16'h5400, 16'hC000, 16'h5C00, 16'h5700, 16'h7C00, 16'hD700,
        16'hDF00, 16'hF500,
        16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h5F70
    };

    // Element pattern of one character; lowercase folds to upper
    function automatic logic [15:0] pattern_of(input logic [7:0] c);
        logic [7:0]  v;
        logic [15:0] p;
        v = c;
        p = '0;
        if (v >= LOWER_A && v <= LOWER_Z) begin
            v = v - CASE_DIFF;
        end
        if (v >= ROM_FIRST && v <= ROM_LAST) begin
            p = MORSE_ROM[6'(v - ROM_FIRST)];
        end
        return p;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/morse_beacon_keyer_unit.sv */
// A tick result is registered in the output register, or in the skid if that one is full.
// Throughput: one transaction per cycle while the skid is empty; message writes give no result.
// The message store is a synchronous-read memory; the next character is prefetched every cycle.
// A two-entry output (register plus skid) lets the input run while a result waits.
// Reset (synchronous, active low) clears the keyer to carrier off at message start;
// message store contents stay undefined until written. Depends on mbk_pkg.
`default_nettype none

module morse_beacon_keyer_unit #(
    parameter int unsigned MSG_DEPTH = 64
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // configuration writes
    input  wire logic                       i_cfg_we,
    input  wire logic                       i_cfg_idx,
    input  wire logic [7:0]                 i_cfg_data,
    // slave side
    input  wire logic                       i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  wire logic [mbk_pkg::DATA_W-1:0] i_s_axis_tdata,  // [5:0] address, [13:6] char_code
    input  wire logic                       i_s_axis_tuser,  // [0] operation
    // master side
    output logic                            o_m_axis_tvalid,
    input  wire logic                       i_m_axis_tready,
    output logic [mbk_pkg::DATA_W-1:0]      o_m_axis_tdata   // [0] key, [1] key_rise,
                                                             // [2] key_fall, [8:3] char_position
);

    localparam int unsigned AW = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1;
    localparam int unsigned LW = ((AW + 1) > 7) ? (AW + 1) : 7;

    // configuration registers
    logic [7:0] r_carrier_time;
    logic [6:0] r_msg_len;

    // keyer state
    logic [AW-1:0] r_char_pos, n_char_pos;
    logic [15:0]   r_pat, n_pat;
    logic [7:0]    r_on, n_on;
    logic [2:0]    r_off, n_off;
    logic          r_key, n_key;
    logic          r_start, n_start;

    // message store and prefetch
    logic [7:0]    r_mem [MSG_DEPTH];
    logic [7:0]    r_first_char;
    logic [7:0]    r_next_char;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          wr_en;

    // output register and skid stage
    logic                      r_out_valid;
    logic [mbk_pkg::DATA_W-1:0] r_out_data;
    logic                      r_skid_valid;
    logic [mbk_pkg::DATA_W-1:0] r_skid_data;
    logic [mbk_pkg::DATA_W-1:0] res_data;

    logic         in_fire;
    logic         tick_fire;
    logic         out_fire;
    mbk_pkg::t_op in_op;
    logic [5:0]   in_addr;
    logic [7:0]   in_char;

    assign in_op   = mbk_pkg::t_op'(i_s_axis_tuser);
    assign in_addr = i_s_axis_tdata[5:0];
    assign in_char = i_s_axis_tdata[13:6];

    assign o_s_axis_tready = i_rst_n && !r_skid_valid;
    assign in_fire   = i_s_axis_tvalid && o_s_axis_tready;
    assign tick_fire = in_fire && (in_op == mbk_pkg::OP_TICK);
    assign out_fire  = r_out_valid && i_m_axis_tready;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carrier_time <= '0;
            r_msg_len      <= 7'd1;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == 1'b0) begin
                r_carrier_time <= i_cfg_data;
            end else begin
                r_msg_len <= i_cfg_data[6:0];
            end
        end
    end

    // message store: write port, prefetch of the character after the next position
    assign wr_en   = in_fire && (in_op == mbk_pkg::OP_WRITE)
                     && (32'(in_addr) < 32'(MSG_DEPTH));
    assign wr_addr = AW'(in_addr);
    assign rd_addr = (i_rst_n ? n_char_pos : '0) + AW'(1);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= in_char;
        end
        if (wr_en && wr_addr == rd_addr) begin
            r_next_char <= in_char;
        end else begin
            r_next_char <= r_mem[rd_addr];
        end
        if (wr_en && wr_addr == '0) begin
            r_first_char <= in_char;
        end
    end

    // keyer next state for one tick
    always_comb begin
        logic [LW-1:0] len;
        logic [LW-1:0] pos;
        logic [1:0]    sig;
        logic          in_len;
        len        = LW'(r_msg_len);
        pos        = LW'(r_char_pos);
        sig        = '0;
        in_len     = 1'b0;
        n_pat      = r_pat;
        n_on       = r_on;
        n_off      = r_off;
        n_key      = r_key;
        n_start    = r_start;
        if (len == '0) begin
            len = LW'(1);
        end
        if (len > LW'(MSG_DEPTH)) begin
            len = LW'(MSG_DEPTH);
        end
        if (tick_fire) begin
            // element boundary
            if (r_on == '0 && r_off == '0) begin
                if (r_start) begin
                    pos     = '0;
                    n_pat   = mbk_pkg::pattern_of(r_first_char);
                    n_start = 1'b0;
                end
                sig = n_pat[15:14];
                if (sig == mbk_pkg::SIG_END) begin
                    pos    = pos + LW'(1);
                    in_len = pos < len;
                    if (in_len && r_next_char == mbk_pkg::CHAR_SPACE) begin
                        n_off = mbk_pkg::GAP_WORD;
                    end else begin
                        if (in_len) begin
                            n_pat = mbk_pkg::pattern_of(r_next_char);
                        end
                        n_off = mbk_pkg::GAP_LETTER;
                    end
                end else begin
                    n_on  = (sig == mbk_pkg::SIG_DAH) ? mbk_pkg::DAH_UNITS
                                                      : mbk_pkg::DIT_UNITS;
                    n_off = mbk_pkg::GAP_ELEM;
                    n_pat = {n_pat[13:0], 2'b00};
                end
                // message end: steady carrier, then restart
                if (pos >= len) begin
                    n_on    = r_carrier_time;
                    pos     = '0;
                    n_start = 1'b1;
                end
            end
            // count down the current on or off period
            if (n_on != '0) begin
                n_key = 1'b1;
                n_on  = n_on - 8'd1;
            end else if (n_off != '0) begin
                n_key = 1'b0;
                n_off = n_off - 3'd1;
            end
        end
        n_char_pos = AW'(pos);
    end

    assign res_data = mbk_pkg::DATA_W'({6'(n_char_pos), (r_key && !n_key),
                                        (!r_key && n_key), n_key});

    // keyer state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_pos <= '0;
            r_pat      <= '0;
            r_on       <= '0;
            r_off      <= '0;
            r_key      <= 1'b0;
            r_start    <= 1'b1;
        end else begin
            r_char_pos <= n_char_pos;
            r_pat      <= n_pat;
            r_on       <= n_on;
            r_off      <= n_off;
            r_key      <= n_key;
            r_start    <= n_start;
        end
    end

    // output register and skid: valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_skid_valid <= 1'b0;
            end
        end else if (tick_fire) begin
            if (!r_out_valid || out_fire) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register and skid: payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_out_data <= r_skid_data;
            end
        end else if (tick_fire) begin
            if (!r_out_valid || out_fire) begin
                r_out_data <= res_data;
            end else begin
                r_skid_data <= res_data;
            end
        end
    end

    // checks
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage holds a result while the output register is empty");

    a_rise_fall_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_data[1] && r_out_data[2]))
        else $error("key rise and fall flagged in the same result");

    a_on_means_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_on != '0) |-> r_key)
        else $error("on period counting while key is off");

    a_off_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_off <= mbk_pkg::GAP_WORD)
        else $error("off counter beyond word gap");

    a_reset_start: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_start && !r_key && !r_out_valid))
        else $error("keyer not at message start after reset");

endmodule

`default_nettype wire
